[src/qse_pkg.sv]
// shared types, codes and constants for the quadrature speed estimator
`default_nettype none
package qse_pkg;

    // item kinds
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNTS_PER_REV = 2'd0;
    localparam logic [1:0] CFG_DIR_REVERSE    = 2'd1;
    localparam logic [1:0] CFG_FILTER_RC      = 2'd2;
    localparam logic [1:0] CFG_COUNTER_16BIT  = 2'd3;

    // configuration reset values
    localparam logic [23:0] CPR_RESET = 24'd4096;

    // speed scale: 60 * 256 * 10^6 split as 234375 << 16 over 2^16 digits
    localparam logic [17:0] SPEED_ODD = 18'd234375;
    // angle scale 360 * 256 = 90 << 10
    localparam logic [6:0]  ANGLE_ODD = 7'd90;

    // serial divider lengths in quotient bits
    localparam logic [5:0] SPD_QBITS = 6'd32;
    localparam logic [5:0] FLT_QBITS = 6'd33;
    localparam logic [5:0] ANG_QBITS = 6'd48;

    // input and result words
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] counter_value;
        logic [19:0] elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] position_total;
        logic signed [47:0] angle_deg_q8;
        logic signed [31:0] speed_rpm_q8;
    } t_out_word;

    // request to the serial divider
    typedef struct packed {
        logic        start;
        logic [43:0] rem;
        logic [47:0] low;
        logic [5:0]  count;
        logic [43:0] divisor;
    } t_div_req;

endpackage
`default_nettype wire

[src/quadrature_speed_estimator.sv]
// top level: sequencer, state and result register of the speed estimator
// an update runs serial divides of 32, 33 and 48 quotient bits, one bit per cycle;
//   start, clear and ignored words run only the angle divide; a divide that would saturate is skipped
// flow: one word at a time, taken the cycle after the result is loaded;
//   the sequencer waits while the result is stalled
// reset: synchronous active low, restores register defaults and clears the state
`default_nettype none
module quadrature_speed_estimator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  qse_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output qse_pkg::t_out_word  o_out_word,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_idx,
    input  wire [23:0]          i_cfg_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UPD     = 4'd1;
    localparam logic [3:0] ST_SPD_CHK = 4'd2;
    localparam logic [3:0] ST_SPD_DIV = 4'd3;
    localparam logic [3:0] ST_FLT_MUL = 4'd4;
    localparam logic [3:0] ST_FLT_GO  = 4'd5;
    localparam logic [3:0] ST_FLT_DIV = 4'd6;
    localparam logic [3:0] ST_ANG_MUL = 4'd7;
    localparam logic [3:0] ST_ANG_CHK = 4'd8;
    localparam logic [3:0] ST_ANG_DIV = 4'd9;
    localparam logic [3:0] ST_DONE    = 4'd10;

    logic [3:0]         r_state;
    qse_pkg::t_in_word  r_in;

    logic [23:0] r_cpr;
    logic        r_rev;
    logic [23:0] r_rc;
    logic        r_is16;

    logic [31:0] r_prev;
    logic [63:0] r_tot;
    logic [31:0] r_filt;

    logic [48:0] r_a;
    logic [43:0] r_d;
    logic        r_neg;
    logic [31:0] r_raw;
    logic [52:0] r_fn;
    logic [24:0] r_fdiv;
    logic        r_dneg;
    logic [70:0] r_ap;
    logic        r_tneg;
    logic [47:0] r_angle;

    logic               r_out_valid;
    qse_pkg::t_out_word r_out;
    logic               w_out_load;

    qse_pkg::t_div_req  w_req;
    logic               w_div_done;
    logic [47:0]        w_quot;

    logic [31:0] w_diff32;
    logic [32:0] w_delta;
    logic [32:0] w_delta_dir;
    logic [32:0] w_delta_neg;
    logic [31:0] w_dmag;
    logic [64:0] w_sum;
    logic [63:0] w_tot_next;
    logic        w_do_update;
    logic [32:0] w_fdiff;
    logic [32:0] w_fdiff_neg;
    logic [32:0] w_fmag;
    logic [33:0] w_nf;
    logic [31:0] w_nf_sat;
    logic [63:0] w_tmag;
    logic [31:0] w_spd_q;
    logic [47:0] w_ang_q;

    // count difference, wrapped and signed
    assign w_diff32    = r_in.counter_value - r_prev;
    assign w_delta     = r_is16 ? {{17{w_diff32[15]}}, w_diff32[15:0]}
                                : {w_diff32[31], w_diff32};
    assign w_delta_dir = r_rev ? (33'd0 - w_delta) : w_delta;
    assign w_delta_neg = 33'd0 - w_delta_dir;
    assign w_dmag      = w_delta_dir[32] ? w_delta_neg[31:0] : w_delta_dir[31:0];
    assign w_do_update = (r_in.elapsed_us != 20'd0) && (r_cpr != 24'd0);

    // saturating position total
    assign w_sum = {r_tot[63], r_tot} + {{32{w_delta_dir[32]}}, w_delta_dir};
    always_comb begin
        if (w_sum[64] != w_sum[63]) begin
            w_tot_next = w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            w_tot_next = w_sum[63:0];
        end
    end

    // filter difference and new filtered value
    assign w_fdiff     = {r_raw[31], r_raw} - {r_filt[31], r_filt};
    assign w_fdiff_neg = 33'd0 - w_fdiff;
    assign w_fmag      = w_fdiff[32] ? w_fdiff_neg : w_fdiff;
    assign w_nf = r_dneg ? ({{2{r_filt[31]}}, r_filt} - {1'b0, w_quot[32:0]})
                         : ({{2{r_filt[31]}}, r_filt} + {1'b0, w_quot[32:0]});
    always_comb begin
        if (w_nf[33:31] == 3'b000 || w_nf[33:31] == 3'b111) begin
            w_nf_sat = w_nf[31:0];
        end else begin
            w_nf_sat = w_nf[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
    end

    // total magnitude and divider quotients
    assign w_tmag  = r_tot[63] ? (64'd0 - r_tot) : r_tot;
    assign w_spd_q = w_quot[31:0];
    assign w_ang_q = w_quot;

    // divider requests
    always_comb begin
        w_req = '0;
        case (r_state)
            ST_SPD_CHK: begin
                w_req.start   = ({11'd0, r_a[48:16]} < r_d);
                w_req.rem     = {11'd0, r_a[48:16]};
                w_req.low     = {r_a[15:0], 32'd0};
                w_req.count   = qse_pkg::SPD_QBITS;
                w_req.divisor = r_d;
            end
            ST_FLT_GO: begin
                w_req.start   = 1'b1;
                w_req.rem     = {24'd0, r_fn[52:33]};
                w_req.low     = {r_fn[32:0], 15'd0};
                w_req.count   = qse_pkg::FLT_QBITS;
                w_req.divisor = {19'd0, r_fdiv};
            end
            ST_ANG_CHK: begin
                w_req.start   = (r_ap[70:38] < {9'd0, r_cpr});
                w_req.rem     = {11'd0, r_ap[70:38]};
                w_req.low     = {r_ap[37:0], 10'd0};
                w_req.count   = qse_pkg::ANG_QBITS;
                w_req.divisor = {20'd0, r_cpr};
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    qse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr  <= qse_pkg::CPR_RESET;
            r_rev  <= 1'b0;
            r_rc   <= 24'd0;
            r_is16 <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qse_pkg::CFG_COUNTS_PER_REV: r_cpr  <= i_cfg_data;
                qse_pkg::CFG_DIR_REVERSE:    r_rev  <= i_cfg_data[0];
                qse_pkg::CFG_FILTER_RC:      r_rc   <= i_cfg_data;
                qse_pkg::CFG_COUNTER_16BIT:  r_is16 <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // result slot is free or being emptied
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // sequencer and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= 32'd0;
            r_tot       <= 64'd0;
            r_filt      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_word;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_state <= ST_ANG_MUL;
                    case (r_in.kind)
                        qse_pkg::KIND_UPDATE: begin
                            if (w_do_update) begin
                                r_prev  <= r_in.counter_value;
                                r_tot   <= w_tot_next;
                                r_neg   <= w_delta_dir[32];
                                r_a     <= 49'(w_dmag) * 49'(qse_pkg::SPEED_ODD);
                                r_d     <= 44'(r_cpr) * 44'(r_in.elapsed_us);
                                r_state <= ST_SPD_CHK;
                            end
                        end
                        qse_pkg::KIND_START: begin
                            r_prev <= r_in.counter_value;
                        end
                        qse_pkg::KIND_CLEAR: begin
                            r_prev <= 32'd0;
                            r_tot  <= 64'd0;
                            r_filt <= 32'd0;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SPD_CHK: begin
                    if (w_req.start) begin
                        r_state <= ST_SPD_DIV;
                    end else begin
                        r_raw   <= r_neg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                        r_state <= ST_FLT_MUL;
                    end
                end
                ST_SPD_DIV: begin
                    if (w_div_done) begin
                        if (w_spd_q[31]) begin
                            r_raw <= r_neg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                        end else begin
                            r_raw <= r_neg ? (32'd0 - w_spd_q) : w_spd_q;
                        end
                        r_state <= ST_FLT_MUL;
                    end
                end
                ST_FLT_MUL: begin
                    r_dneg  <= w_fdiff[32];
                    r_fn    <= 53'(w_fmag) * 53'(r_in.elapsed_us);
                    r_fdiv  <= 25'(r_rc) + 25'(r_in.elapsed_us);
                    r_state <= ST_FLT_GO;
                end
                ST_FLT_GO: begin
                    r_state <= ST_FLT_DIV;
                end
                ST_FLT_DIV: begin
                    if (w_div_done) begin
                        r_filt  <= w_nf_sat;
                        r_state <= ST_ANG_MUL;
                    end
                end
                ST_ANG_MUL: begin
                    if (r_cpr == 24'd0) begin
                        r_angle <= 48'd0;
                        r_state <= ST_DONE;
                    end else begin
                        r_tneg  <= r_tot[63];
                        r_ap    <= 71'(w_tmag) * 71'(qse_pkg::ANGLE_ODD);
                        r_state <= ST_ANG_CHK;
                    end
                end
                ST_ANG_CHK: begin
                    if (w_req.start) begin
                        r_state <= ST_ANG_DIV;
                    end else begin
                        r_angle <= r_tneg ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                        r_state <= ST_DONE;
                    end
                end
                ST_ANG_DIV: begin
                    if (w_div_done) begin
                        if (r_tneg) begin
                            r_angle <= (w_ang_q[47] && (w_ang_q[46:0] != 47'd0))
                                       ? {1'b1, 47'd0} : (48'd0 - w_ang_q);
                        end else begin
                            r_angle <= w_ang_q[47] ? {1'b0, {47{1'b1}}} : w_ang_q;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.position_total <= r_tot;
            r_out.angle_deg_q8   <= r_angle;
            r_out.speed_rpm_q8   <= r_filt;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

[src/qse_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module qse_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  qse_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic [47:0]        o_quot
);

    logic [43:0] r_rem;
    logic [47:0] r_sh;
    logic [43:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [44:0] w_trial;
    logic        w_ge;
    logic [44:0] w_sub;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_sh[47]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_sub   = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_sh  <= i_req.low;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[43:0] : w_trial[43:0];
            r_sh  <= {r_sh[46:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule
`default_nettype wire

[src/qse_chk.sv]
// port-level checker for the speed estimator and its bind
`default_nettype none
module qse_chk (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input qse_pkg::t_out_word  o_out_word
);

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while busy");

    // nothing to deliver straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a zero total always gives a zero angle
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.position_total == 64'sd0)
            |-> (o_out_word.angle_deg_q8 == 48'sd0))
        else $error("nonzero angle with zero total");

endmodule

bind quadrature_speed_estimator qse_chk u_qse_chk (.*);
`default_nettype wire
